@@ hdl/simd_pkg.sv @@
// ----------------------------------------------------------------------------
// simd_pkg
// Shared types and codes for the sorted insert / merge / dedup block.
// ----------------------------------------------------------------------------
package simd_pkg;

  // op codes of an input word
  localparam logic [1:0] OP_INS_A = 2'd0;
  localparam logic [1:0] OP_INS_B = 2'd1;
  localparam logic [1:0] OP_MERGE = 2'd2;

  // origin tags of a result word
  localparam logic [1:0] ORIGIN_A    = 2'd0;
  localparam logic [1:0] ORIGIN_B    = 2'd1;
  localparam logic [1:0] ORIGIN_BOTH = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] merged_value;
    logic [1:0]         origin;
    logic               overflow;
    logic               last;
  } out_word_t;

endpackage

@@ hdl/sorted_insert_merge_dedup.sv @@
// ----------------------------------------------------------------------------
// sorted_insert_merge_dedup
// Two ascending signed lists with sorted insert and a deduplicating merge.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one word with
//   an op and a value. Insert A / insert B place the value into that list in
//   sorted position, ahead of equal entries. An insert into a full list is
//   dropped and sets a sticky overflow flag. Merge streams the ordered merge
//   of both lists on the output channel, one word per cycle; equal heads are
//   sent once tagged "both". The final word carries last; every word of a
//   merge carries the overflow flag. The merge then clears both lists and
//   the flag. A merge of two empty lists sends nothing. Unused op is ignored.
// Timing:
//   An insert at sorted position p into a list of n entries starts after the
//   accept at slot n, one shared compare per cycle walking down the
//   list. A merge of na and nb entries sends up to na + nb words, one per
//   cycle through the same comparator. in_ready_o is high only while idle.
// Reset: lists empty, flag clear, output empty. List storage is not reset.
// Stall: a stalled output word holds; the merge waits for it to be taken.
// ----------------------------------------------------------------------------
module sorted_insert_merge_dedup
  import simd_pkg::*;
#(
  parameter int LIST_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_INSERT = 3'b010,
    ST_MERGE  = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic signed [31:0] list_a_q [LIST_DEPTH];
  logic signed [31:0] list_b_q [LIST_DEPTH];
  logic [CW-1:0]      cnt_a_q, cnt_a_d;
  logic [CW-1:0]      cnt_b_q, cnt_b_d;
  logic               ovf_q, ovf_d;
  logic               sel_b_q, sel_b_d;   // insert target is list B
  logic [CW-1:0]      pos_q, pos_d;       // insert slot being filled
  logic signed [31:0] val_q, val_d;       // value being inserted
  logic [CW-1:0]      ia_q, ia_d;         // merge read pointers
  logic [CW-1:0]      ib_q, ib_d;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_q, out_d;

  // list write port
  logic               we_a, we_b;
  logic [IW-1:0]      waddr;
  logic signed [31:0] wdata;

  // read side
  logic [CW-1:0]      pos_m1;
  logic [IW-1:0]      idx_a, idx_b;
  logic signed [31:0] rd_a, rd_b;

  // shared comparator
  logic signed [31:0] cmp_x, cmp_y;
  logic               cmp_lt, cmp_eq;

  // merge step
  logic               a_done, b_done;
  logic [CW-1:0]      ia_n, ib_n;

  assign pos_m1 = pos_q - CW'(1);
  assign idx_a  = (state_q == ST_INSERT) ? pos_m1[IW-1:0] : ia_q[IW-1:0];
  assign idx_b  = (state_q == ST_INSERT) ? pos_m1[IW-1:0] : ib_q[IW-1:0];
  assign rd_a   = list_a_q[idx_a];
  assign rd_b   = list_b_q[idx_b];

  // insert: entry below the slot vs new value; merge: head A vs head B
  assign cmp_x  = (state_q == ST_INSERT) ? (sel_b_q ? rd_b : rd_a) : rd_a;
  assign cmp_y  = (state_q == ST_INSERT) ? val_q : rd_b;
  assign cmp_lt = cmp_x < cmp_y;
  assign cmp_eq = cmp_x == cmp_y;

  assign a_done = (ia_q == cnt_a_q);
  assign b_done = (ib_q == cnt_b_q);

  always_comb begin
    state_d     = state_q;
    cnt_a_d     = cnt_a_q;
    cnt_b_d     = cnt_b_q;
    ovf_d       = ovf_q;
    sel_b_d     = sel_b_q;
    pos_d       = pos_q;
    val_d       = val_q;
    ia_d        = ia_q;
    ib_d        = ib_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    we_a        = 1'b0;
    we_b        = 1'b0;
    waddr       = pos_q[IW-1:0];
    wdata       = val_q;
    ia_n        = ia_q;
    ib_n        = ib_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.op)
            OP_INS_A: begin
              if (cnt_a_q == CW'(LIST_DEPTH)) begin
                ovf_d = 1'b1;
              end else begin
                sel_b_d = 1'b0;
                pos_d   = cnt_a_q;
                val_d   = in_data_i.value;
                state_d = ST_INSERT;
              end
            end
            OP_INS_B: begin
              if (cnt_b_q == CW'(LIST_DEPTH)) begin
                ovf_d = 1'b1;
              end else begin
                sel_b_d = 1'b1;
                pos_d   = cnt_b_q;
                val_d   = in_data_i.value;
                state_d = ST_INSERT;
              end
            end
            OP_MERGE: begin
              ia_d = '0;
              ib_d = '0;
              if (cnt_a_q == '0 && cnt_b_q == '0) begin
                ovf_d = 1'b0;
              end else begin
                state_d = ST_MERGE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_INSERT: begin
        // walk down: shift up every entry not below the new value
        we_a = ~sel_b_q;
        we_b = sel_b_q;
        if (pos_q != '0 && !cmp_lt) begin
          wdata = cmp_x;
          pos_d = pos_m1;
        end else begin
          wdata   = val_q;
          state_d = ST_IDLE;
          if (sel_b_q) begin
            cnt_b_d = cnt_b_q + CW'(1);
          end else begin
            cnt_a_d = cnt_a_q + CW'(1);
          end
        end
      end

      ST_MERGE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.overflow = ovf_q;
          if (b_done) begin
            out_d.merged_value = rd_a;
            out_d.origin       = ORIGIN_A;
            ia_n               = ia_q + CW'(1);
          end else if (a_done) begin
            out_d.merged_value = rd_b;
            out_d.origin       = ORIGIN_B;
            ib_n               = ib_q + CW'(1);
          end else if (cmp_lt) begin
            out_d.merged_value = rd_a;
            out_d.origin       = ORIGIN_A;
            ia_n               = ia_q + CW'(1);
          end else if (cmp_eq) begin
            // equal heads: one word, B's copy dropped
            out_d.merged_value = rd_a;
            out_d.origin       = ORIGIN_BOTH;
            ia_n               = ia_q + CW'(1);
            ib_n               = ib_q + CW'(1);
          end else begin
            out_d.merged_value = rd_b;
            out_d.origin       = ORIGIN_B;
            ib_n               = ib_q + CW'(1);
          end
          out_d.last  = (ia_n == cnt_a_q) && (ib_n == cnt_b_q);
          out_valid_d = 1'b1;
          ia_d        = ia_n;
          ib_d        = ib_n;
          if (out_d.last) begin
            cnt_a_d = '0;
            cnt_b_d = '0;
            ovf_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and pointers, no reset needed
  always_ff @(posedge clk_i) begin
    sel_b_q <= sel_b_d;
    pos_q   <= pos_d;
    val_q   <= val_d;
    ia_q    <= ia_d;
    ib_q    <= ib_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      list_a_q[waddr] <= wdata;
    end
    if (we_b) begin
      list_b_q[waddr] <= wdata;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hdl/simd_checker.sv @@
// ----------------------------------------------------------------------------
// simd_checker
// Port-level checks for sorted_insert_merge_dedup, bound to the top level.
// ----------------------------------------------------------------------------
module simd_checker
  import simd_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_word_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_data_o
);

  // offered input word holds until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input word changed while waiting");

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // no unused origin tag
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.origin == ORIGIN_A ||
                     out_data_o.origin == ORIGIN_B ||
                     out_data_o.origin == ORIGIN_BOTH))
    else $error("bad origin tag");

  // mid-merge the input side is closed
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> !in_ready_o)
    else $error("input open during merge");

  // reset empties the output
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid after reset");

endmodule

bind sorted_insert_merge_dedup simd_checker u_simd_checker (.*);

@@ bench/sorted_insert_merge_dedup_test.sv @@
// ----------------------------------------------------------------------------
// sorted_insert_merge_dedup_test
// Self-checking bench for the two-list sorted insert / dedup merge block.
// It mirrors both lists and the overflow flag in a local predictor, queues
// the expected merge words at each accepted merge, and checks every result
// word against them. Handshake idling changes between phases. One phase holds
// the output off long enough to stall the input.
// ----------------------------------------------------------------------------
module sorted_insert_merge_dedup_test;
  import simd_pkg::*;

  localparam int LIST_DEPTH = 16;
  // unused op code: the block must ignore it
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // longest insert walk plus margin; waited out before the end
  localparam int SETTLE_CYCLES = 2 * LIST_DEPTH + 8;
  // long output hold-off used to back the block up
  localparam int HOLD_CYCLES = 400;
  // cycles without any accepted word before giving up
  localparam int QUIET_LIMIT = 3000;
  localparam int LIST_A = 0;
  localparam int LIST_B = 1;

  logic      clk_i;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  sorted_insert_merge_dedup #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  in_word_t  word_q[$];                 // words waiting to be offered
  out_word_t merge_words_due[$];        // merge words still to arrive
  int        queued_items   = 0;        // inserts and merges queued so far
  int        fail_count     = 0;
  int        send_idle_pct  = 0;
  int        recv_idle_pct  = 0;
  int        hold_token     = 0;        // bumped to request an output hold-off

  // Mirror of the block: both lists kept ascending, plus the sticky flag.
  logic signed [31:0] sorted_list [2][LIST_DEPTH];
  int                 list_len [2];
  logic               drop_seen;

  task automatic report_fail(input string msg);
    if (fail_count < 50) $display("MISMATCH: %s", msg);
    fail_count++;
  endtask

  // Insert ahead of equal entries; a full list drops the value and flags it.
  function automatic void list_insert(input int sel, input logic signed [31:0] v);
    int pos;
    pos = 0;
    if (list_len[sel] >= LIST_DEPTH) begin
      drop_seen = 1'b1;
      return;
    end
    while (pos < list_len[sel] && sorted_list[sel][pos] < v) pos++;
    for (int i = list_len[sel]; i > pos; i--) sorted_list[sel][i] = sorted_list[sel][i-1];
    sorted_list[sel][pos] = v;
    list_len[sel]++;
  endfunction

  // Walk both heads: equal heads go out once tagged both, B's copy dropped.
  // The previous word is held back so the final one can be marked last.
  function automatic void merge_lists();
    int                 ia, ib;
    logic signed [31:0] v;
    logic [1:0]         org;
    out_word_t          held;
    logic               have_held;
    ia = 0;
    ib = 0;
    have_held = 1'b0;
    held = '0;
    while (ia < list_len[LIST_A] || ib < list_len[LIST_B]) begin
      if (ib >= list_len[LIST_B] ||
          (ia < list_len[LIST_A] && sorted_list[LIST_A][ia] < sorted_list[LIST_B][ib])) begin
        v   = sorted_list[LIST_A][ia];
        org = ORIGIN_A;
        ia++;
      end else if (ia >= list_len[LIST_A] ||
                   sorted_list[LIST_B][ib] < sorted_list[LIST_A][ia]) begin
        v   = sorted_list[LIST_B][ib];
        org = ORIGIN_B;
        ib++;
      end else begin
        v   = sorted_list[LIST_A][ia];
        org = ORIGIN_BOTH;
        ia++;
        ib++;
      end
      if (have_held) merge_words_due.push_back(held);
      held = '{merged_value: v, origin: org, overflow: drop_seen, last: 1'b0};
      have_held = 1'b1;
    end
    if (have_held) begin
      held.last = 1'b1;
      merge_words_due.push_back(held);
    end
    // every merge clears, even an empty one
    list_len[LIST_A] = 0;
    list_len[LIST_B] = 0;
    drop_seen = 1'b0;
  endfunction

  function automatic void apply_word(input in_word_t w);
    case (w.op)
      OP_INS_A: list_insert(LIST_A, w.value);
      OP_INS_B: list_insert(LIST_B, w.value);
      OP_MERGE: merge_lists();
      default: ;
    endcase
  endfunction

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (merge_words_due.size() == 0) begin
      report_fail($sformatf("unexpected word, value %0d origin %0d",
                            got.merged_value, got.origin));
      return;
    end
    want = merge_words_due.pop_front();
    if (got.merged_value !== want.merged_value)
      report_fail($sformatf("merged_value got %0d expected %0d",
                            got.merged_value, want.merged_value));
    if (got.origin !== want.origin)
      report_fail($sformatf("origin got %0d expected %0d (value %0d)",
                            got.origin, want.origin, want.merged_value));
    if (got.overflow !== want.overflow)
      report_fail($sformatf("overflow got %0b expected %0b (value %0d)",
                            got.overflow, want.overflow, want.merged_value));
    if (got.last !== want.last)
      report_fail($sformatf("last got %0b expected %0b (value %0d)",
                            got.last, want.last, want.merged_value));
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued words, holds each until accepted, idles at random.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      list_len[LIST_A] = 0;
      list_len[LIST_B] = 0;
      drop_seen = 1'b0;
    end else begin
      if (in_valid && in_ready) apply_word(in_data);
      // only move on once the current word is gone; valid never drops early
      if (!in_valid || in_ready) begin
        if (word_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= word_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks every taken result word, drives ready with random stalls
  // and runs the long hold-off when one is requested.
  // --------------------------------------------------------------------------
  int hold_seen = 0;
  int hold_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_word(out_data);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long with no word moving on either side ends the run.
  // --------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_word(input logic [1:0] op, input logic signed [31:0] v);
    word_q.push_back('{op: op, value: v});
    if (op != OP_UNUSED) queued_items++;
  endtask

  // Small values collide often (equal heads, duplicates); the rest covers
  // the extremes and every bit of the value.
  function automatic logic signed [31:0] rand_value();
    int r;
    r = $urandom_range(9);
    if (r < 4) return int'($urandom_range(16)) - 8;
    if (r == 4) begin
      case ($urandom_range(5))
        0: return 32'sh8000_0000;
        1: return 32'sh8000_0001;
        2: return 32'sh7fff_ffff;
        3: return 32'sh7fff_fffe;
        4: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // Mostly short lists; some near full; a few overfill to hit the flag.
  function automatic int pick_len();
    int r;
    r = $urandom_range(9);
    if (r < 7) return $urandom_range(6);
    if (r < 9) return $urandom_range(16, 7);
    return $urandom_range(20, 16);
  endfunction

  // One well-formed set: interleaved inserts into both lists, then a merge,
  // with the odd unused-op word thrown in as noise.
  task automatic queue_merge_set(input int na, input int nb);
    int ra, rb;
    ra = na;
    rb = nb;
    while (ra + rb > 0) begin
      if ($urandom_range(19) == 0) push_word(OP_UNUSED, $urandom);
      if ($urandom_range(ra + rb - 1) < ra) begin
        push_word(OP_INS_A, rand_value());
        ra--;
      end else begin
        push_word(OP_INS_B, rand_value());
        rb--;
      end
    end
    push_word(OP_MERGE, $urandom);
  endtask

  task automatic queue_random(input int n_items);
    int target;
    target = queued_items + n_items;
    while (queued_items < target) queue_merge_set(pick_len(), pick_len());
  endtask

  // Sender pause: everything offered is taken and every result is back.
  task automatic drain();
    while (word_q.size() > 0 || in_valid || merge_words_due.size() > 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty merge, unused op, extremes, equal heads in both lists,
    // duplicates within A, then a B-only tail and an A-only tail.
    send_idle_pct = 18;
    recv_idle_pct = 56;
    push_word(OP_MERGE, 32'sd0);
    push_word(OP_UNUSED, -32'sd1);
    push_word(OP_INS_A, 32'sh7fff_ffff);
    push_word(OP_INS_A, 32'sh8000_0000);
    push_word(OP_INS_A, 32'sd0);
    push_word(OP_INS_A, -32'sd1);
    push_word(OP_INS_A, 32'sd5);
    push_word(OP_INS_A, 32'sd5);
    push_word(OP_INS_B, 32'sd5);
    push_word(OP_INS_B, 32'sh8000_0000);
    push_word(OP_INS_B, 32'sd7);
    push_word(OP_INS_B, -32'sd1);
    push_word(OP_INS_B, 32'sh7fff_ffff);
    push_word(OP_MERGE, -32'sd1);
    push_word(OP_INS_B, 32'sd3);
    push_word(OP_INS_B, 32'sd4);
    push_word(OP_INS_A, 32'sd1);
    push_word(OP_MERGE, 32'sd0);
    push_word(OP_INS_A, 32'sd2);
    push_word(OP_INS_A, 32'sd2);
    push_word(OP_MERGE, 32'sd0);
    drain();

    // Phase 1: sender idles lightly, receiver heavily.
    queue_random(150);
    drain();

    // Phase 2: roles swapped. Opens with a full A list merged while the
    // receiver holds off, with more inserts queued behind the merge so the
    // input backs up against the stalled output.
    send_idle_pct = 56;
    recv_idle_pct = 18;
    queue_merge_set(16, 3);
    queue_merge_set(2, 2);
    while (merge_words_due.size() == 0) @(posedge clk_i);
    hold_token++;
    queue_random(140);
    drain();

    // Phase 3: no idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(150);
    drain();

    // let any stray word from a late insert walk show up
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (merge_words_due.size() != 0)
      report_fail($sformatf("%0d merge words never arrived", merge_words_due.size()));

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
